// ===== sv/bmp2fb_pkg.sv =====
// Shared types and constants for the BMP stream to frame-buffer writer.
`default_nettype none

package bmp2fb_pkg;

    // Header layout of a 24-bit BMP file.
    localparam int unsigned HDR_LEN    = 54;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned DIM_FIRST  = 18;
    localparam int unsigned WIDTH_LAST = 21;
    localparam int unsigned HGHT_LAST  = 25;

    // Fixed field widths of the ports.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned FB_IDX_W = 20;
    localparam int unsigned PIXEL_W  = 24;

    // Configuration register indexes.
    localparam logic CFG_START_ROW = 1'b0;
    localparam logic CFG_START_COL = 1'b1;

    // One result word.
    typedef struct packed {
        logic [FB_IDX_W-1:0] fb_index;
        logic [PIXEL_W-1:0]  pixel_word;
        logic                last_pixel;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/bmp24_to_framebuffer_writer_top.sv =====
// Top level of the 24-bit BMP stream to frame-buffer writer.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_file_byte, i_first_byte
// output    out        o_out_valid / i_out_stall o_fb_index, o_pixel_word, o_last_pixel
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One file byte is taken every cycle unless the input stalls; every third pixel byte yields a word.
// A word goes into the output register as its red byte is taken, or into the skid stage if the output stalls.
// A one-word skid stage behind the output register keeps the input open
// while a word waits; the input stalls only while the skid stage is full.
// Reset clears the parser, leaving it idle until a byte marked first arrives.
`default_nettype none

module bmp24_to_framebuffer_writer_top
    import bmp2fb_pkg::*;
#(
    parameter int FB_WIDTH  = 640,
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 20
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [BYTE_W-1:0]   i_file_byte,
    input  wire logic                i_first_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [FB_IDX_W-1:0]      o_fb_index,
    output logic [PIXEL_W-1:0]       o_pixel_word,
    output logic                     o_last_pixel,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [COORD_W-1:0]  i_cfg_data
);

    logic [COORD_W-1:0] r_start_row;
    logic [COORD_W-1:0] r_start_col;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;
    logic               in_accept;
    logic               res_valid;
    t_result            res;
    logic               out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= '0;
            r_start_col <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_ROW: r_start_row <= i_cfg_data;
                CFG_START_COL: r_start_col <= i_cfg_data;
                default:       r_start_row <= r_start_row;
            endcase
        end
    end

    bmp2fb_parse #(
        .FB_WIDTH  (FB_WIDTH),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_file_byte  (i_file_byte),
        .i_first_byte (i_first_byte),
        .i_start_row  (r_start_row),
        .i_start_col  (r_start_col),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register with a one-word skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payloads.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fb_index   = r_out.fb_index;
    assign o_pixel_word = r_out.pixel_word;
    assign o_last_pixel = r_out.last_pixel;

endmodule

`default_nettype wire

// ===== sv/bmp2fb_parse.sv =====
// Header parser and pixel address generator, one file byte per cycle while i_accept is high.
`default_nettype none

module bmp2fb_parse
    import bmp2fb_pkg::*;
#(
    parameter int FB_WIDTH  = 640,
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 20
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [BYTE_W-1:0]  i_file_byte,
    input  wire logic               i_first_byte,
    input  wire logic [COORD_W-1:0] i_start_row,
    input  wire logic [COORD_W-1:0] i_start_col,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam int TOP_W = ((COORD_W > DIM_BITS) ? COORD_W : DIM_BITS) + 1;
    localparam logic [ADDR_BITS-1:0] FB_STEP = ADDR_BITS'(FB_WIDTH);

    // Control state.
    logic                 r_done,    n_done;
    logic [POS_W-1:0]     r_hpos,    n_hpos;
    logic [DIM_BITS-1:0]  r_width,   n_width;
    logic [DIM_BITS-1:0]  r_height,  n_height;
    logic [DIM_BITS-1:0]  r_row,     n_row;
    logic [DIM_BITS-1:0]  r_col,     n_col;
    logic [1:0]           r_bip,     n_bip;
    logic [1:0]           r_pad,     n_pad;
    // Payload state.
    logic [31:0]          r_acc,     n_acc;
    logic [BYTE_W-1:0]    r_blue,    n_blue;
    logic [BYTE_W-1:0]    r_green,   n_green;
    logic [ADDR_BITS-1:0] r_row_base, n_row_base;

    // Values seen by this byte after a possible restart.
    logic                 e_done;
    logic [POS_W-1:0]     e_hpos;
    logic [DIM_BITS-1:0]  e_width;
    logic [DIM_BITS-1:0]  e_height;
    logic [31:0]          e_acc;
    logic [1:0]           sh;
    logic [TOP_W-1:0]     top;
    logic [ADDR_BITS-1:0] top_a;
    logic [ADDR_BITS-1:0] top_addr;
    logic [ADDR_BITS-1:0] pix_addr;
    logic                 last_col;
    logic                 last_row;

    // Negative sizes become zero, oversized ones saturate.
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [31:0] v);
        logic [DIM_BITS-1:0] r;
        if (v[31]) begin
            r = '0;
        end else if (|v[30:DIM_BITS]) begin
            r = '1;
        end else begin
            r = v[DIM_BITS-1:0];
        end
        return r;
    endfunction

    // A first byte restarts the header parse.
    assign e_done   = i_first_byte ? 1'b0 : r_done;
    assign e_hpos   = i_first_byte ? '0 : r_hpos;
    assign e_width  = i_first_byte ? '0 : r_width;
    assign e_height = i_first_byte ? '0 : r_height;
    assign e_acc    = i_first_byte ? '0 : r_acc;
    assign sh       = 2'(e_hpos - POS_W'(DIM_FIRST));

    // Address of the image's top row at the end of the header.
    assign top      = TOP_W'(i_start_row) + TOP_W'(e_height) - TOP_W'(1);
    assign top_a    = ADDR_BITS'(top);
    assign top_addr = ADDR_BITS'(top_a * FB_STEP) + ADDR_BITS'(i_start_col);

    // Address of the current pixel and the end-of-row tests.
    assign pix_addr = r_row_base + ADDR_BITS'(r_col);
    assign last_col = ({1'b0, r_col} + (DIM_BITS+1)'(1)) >= {1'b0, r_width};
    assign last_row = ({1'b0, r_row} + (DIM_BITS+1)'(1)) >= {1'b0, r_height};

    // Result payload for the red byte of a pixel.
    assign o_res.fb_index   = FB_IDX_W'(pix_addr);
    assign o_res.pixel_word = {r_blue, r_green, i_file_byte};
    assign o_res.last_pixel = last_col && last_row;

    // Next-state logic for one accepted byte.
    always_comb begin
        n_done     = r_done;
        n_hpos     = r_hpos;
        n_width    = r_width;
        n_height   = r_height;
        n_row      = r_row;
        n_col      = r_col;
        n_bip      = r_bip;
        n_pad      = r_pad;
        n_acc      = r_acc;
        n_blue     = r_blue;
        n_green    = r_green;
        n_row_base = r_row_base;
        o_res_valid = 1'b0;
        if (i_accept) begin
            n_done   = e_done;
            n_hpos   = e_hpos;
            n_width  = e_width;
            n_height = e_height;
            n_acc    = e_acc;
            if (!e_done) begin
                if (e_hpos < POS_W'(HDR_LEN)) begin
                    // Header byte: collect the width and height words.
                    if (e_hpos >= POS_W'(DIM_FIRST) && e_hpos <= POS_W'(HGHT_LAST)) begin
                        if (sh == 2'd0) begin
                            n_acc = 32'(i_file_byte);
                        end else begin
                            n_acc = e_acc | (32'(i_file_byte) << {sh, 3'b000});
                        end
                        if (e_hpos == POS_W'(WIDTH_LAST)) begin
                            n_width = clamp_dim(n_acc);
                        end else if (e_hpos == POS_W'(HGHT_LAST)) begin
                            n_height = clamp_dim(n_acc);
                        end
                    end
                    n_hpos = e_hpos + POS_W'(1);
                    if (e_hpos == POS_W'(HDR_LEN - 1)) begin
                        n_row = '0;
                        n_col = '0;
                        n_bip = 2'd0;
                        n_pad = 2'd0;
                        if (e_width == '0 || e_height == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_row_base = top_addr;
                        end
                    end
                end else if (r_pad != 2'd0) begin
                    // Row padding: the last pad byte moves up one row.
                    n_pad = r_pad - 2'd1;
                    if (r_pad == 2'd1) begin
                        n_col      = '0;
                        n_row      = r_row + DIM_BITS'(1);
                        n_row_base = r_row_base - FB_STEP;
                    end
                end else if (r_bip == 2'd0) begin
                    n_blue = i_file_byte;
                    n_bip  = 2'd1;
                end else if (r_bip == 2'd1) begin
                    n_green = i_file_byte;
                    n_bip   = 2'd2;
                end else begin
                    // Red byte completes a pixel.
                    o_res_valid = 1'b1;
                    n_bip = 2'd0;
                    if (last_col && last_row) begin
                        n_done = 1'b1;
                    end else if (last_col) begin
                        n_pad = r_width[1:0];
                        if (r_width[1:0] == 2'd0) begin
                            n_col      = '0;
                            n_row      = r_row + DIM_BITS'(1);
                            n_row_base = r_row_base - FB_STEP;
                        end
                    end else begin
                        n_col = r_col + DIM_BITS'(1);
                    end
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b1;
            r_hpos   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_bip    <= 2'd0;
            r_pad    <= 2'd0;
        end else begin
            r_done   <= n_done;
            r_hpos   <= n_hpos;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_col    <= n_col;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_blue     <= n_blue;
        r_green    <= n_green;
        r_row_base <= n_row_base;
    end

endmodule

`default_nettype wire
